// ===== rtl/epsc_pkg.sv =====
// ----------------------------------------------------------------------------
// epsc_pkg: shared types and constants of the encoder PID speed controller
// Holds the register map, fixed field widths, the arithmetic constants, the
// multiplier handshake types and the saturation helpers.
// ----------------------------------------------------------------------------
package epsc_pkg;

  // Fixed field widths.
  localparam int unsigned RPM_W    = 13;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned PWM_W    = 16;
  localparam int unsigned PPR_W    = 16;
  localparam int unsigned FRAME_W  = 10;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MP_W     = 15;

  // Saturated value width and derived datapath widths.
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned P1_W     = RPM_W + PPR_W;
  localparam int unsigned P2_W     = P1_W + FRAME_W;
  localparam int unsigned MUL_A_W  = ACC_W + 1;
  localparam int unsigned MUL_P_W  = MUL_A_W + GAIN_W;
  localparam int unsigned MUL_CNT_W = $clog2(GAIN_W);
  localparam int unsigned REM_W    = 16;
  localparam int unsigned WIDE_W   = 64;

  localparam int unsigned GAIN_SHIFT = 8;
  localparam int unsigned WRAP_JUMP  = 16000;
  localparam int unsigned MS_PER_MIN = 60000;

  // Register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_PWM_LIMIT = 3'd3,
    REG_SPD_LIMIT = 3'd4,
    REG_DEAD_BAND = 3'd5,
    REG_PPR       = 3'd6,
    REG_FRAME_MS  = 3'd7
  } cfg_reg_e;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P    = 16'd256;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I    = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D    = 16'd0;
  localparam logic [PWM_W-1:0]   RST_PWM_LIMIT = 16'd1000;
  localparam logic [RPM_W-1:0]   RST_SPD_LIMIT = 13'd300;
  localparam logic [PWM_W-1:0]   RST_DEAD_BAND = 16'd0;
  localparam logic [PPR_W-1:0]   RST_PPR       = 16'd1320;
  localparam logic [FRAME_W-1:0] RST_FRAME_MS  = 10'd20;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic [GAIN_W-1:0]         b;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -64'sh0000_0080_0000_0000;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] y;
    y = x;
    if (x > SAT_MAX) y = SAT_MAX;
    else if (x < SAT_MIN) y = SAT_MIN;
    return y[ACC_W-1:0];
  endfunction

  // Gain product in Q8.8 back to the value scale, floor rounding, saturated.
  function automatic logic signed [ACC_W-1:0] gain_scale(input logic signed [MUL_P_W-1:0] p);
    logic signed [WIDE_W-1:0] w;
    w = WIDE_W'(p);
    return sat_acc(w >>> GAIN_SHIFT);
  endfunction

endpackage

// ===== rtl/encoder_pid_speed_controller_core.sv =====
// ----------------------------------------------------------------------------
// encoder_pid_speed_controller_core: encoder-fed PID speed controller
// One request per control tick: measures encoder pulses, converts the target
// speed to pulses per frame and runs a PID loop with anti-windup.
// ----------------------------------------------------------------------------
// Each request carries the encoder count, the wanted speed in rpm and a
// restart flag, and produces exactly one result: the PWM duty, the two bridge
// pins and the pulses measured in this frame. A restart request clears the
// controller state, takes the encoder count as the new base and returns a zero
// result. Any other request walks a sequencer through five multiplications on
// one shared bit-serial multiplier, a bit-serial restoring division by 60000
// and the error, anti-windup clamp, sum and clip steps before the result is
// handed to the output register.
// Requests are taken one at a time; the result sits in an output register, so
// the next request is accepted while the previous result still waits.
// Configuration writes must only occur while no request is in flight.
// ----------------------------------------------------------------------------
module encoder_pid_speed_controller_core import epsc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 14,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_data_i,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [COUNT_BITS-1:0]        encoder_count_i,
  input  logic [RPM_W-1:0]             target_rpm_i,
  input  logic                         restart_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [PWM_W-1:0]             duty_o,
  output logic                         drive_a_o,
  output logic                         drive_b_o,
  output logic signed [MP_W-1:0]       measured_pulses_o
);

  // Measured pulses carry one extra sign bit over the counter width.
  localparam int unsigned REAL_W  = COUNT_BITS + 1;
  // The dividend is the rpm * ppr * frame product moved up by the fraction.
  localparam int unsigned DVD_W   = P2_W + FRAC_BITS;
  localparam int unsigned DCNT_W  = $clog2(DVD_W);
  localparam int unsigned INT_W   = ACC_W + 1;
  localparam int unsigned ISUM_W  = ACC_W + 2;
  localparam int unsigned TOT_W   = ACC_W + 3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_DIV, ST_ERR, ST_GP, ST_GI,
    ST_CLAMP, ST_GD, ST_SUM, ST_CLIP, ST_OUT
  } state_e;

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [PWM_W-1:0]   pwm_limit_q, dead_band_q;
  logic [RPM_W-1:0]   spd_limit_q;
  logic [PPR_W-1:0]   ppr_q;
  logic [FRAME_W-1:0] frame_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= RST_GAIN_P;
      gain_i_q    <= RST_GAIN_I;
      gain_d_q    <= RST_GAIN_D;
      pwm_limit_q <= RST_PWM_LIMIT;
      spd_limit_q <= RST_SPD_LIMIT;
      dead_band_q <= RST_DEAD_BAND;
      ppr_q       <= RST_PPR;
      frame_ms_q  <= RST_FRAME_MS;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_P:    gain_p_q    <= cfg_data_i;
        REG_GAIN_I:    gain_i_q    <= cfg_data_i;
        REG_GAIN_D:    gain_d_q    <= cfg_data_i;
        REG_PWM_LIMIT: pwm_limit_q <= cfg_data_i;
        REG_SPD_LIMIT: spd_limit_q <= cfg_data_i[RPM_W-1:0];
        REG_DEAD_BAND: dead_band_q <= cfg_data_i;
        REG_PPR:       ppr_q       <= cfg_data_i;
        REG_FRAME_MS:  frame_ms_q  <= cfg_data_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state and per-request working registers.
  state_e                   state_q;
  logic [COUNT_BITS-1:0]    last_count_q, cur_q;
  logic signed [INT_W-1:0]  integral_q;
  logic signed [REAL_W-1:0] last_pulses_q, real_q;
  logic signed [ISUM_W-1:0] isum_q;
  logic signed [ACC_W-1:0]  err_q, prop_q, dterm_q;
  logic signed [TOT_W-1:0]  total_q;
  logic [PWM_W-1:0]         duty_q;
  logic [DVD_W-1:0]         dvd_q, quo_q;
  logic [REM_W-1:0]         rem_q;
  logic [DCNT_W-1:0]        dcnt_q;
  mul_req_t                 mreq_q;
  mul_rsp_t                 mrsp;
  logic                     out_valid_q;
  logic [PWM_W-1:0]         out_duty_q;
  logic signed [MP_W-1:0]   out_mp_q;

  epsc_sermul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq_q),
    .rsp_o  (mrsp)
  );

  // Pulse measurement with counter wrap correction.
  logic [COUNT_BITS-1:0]    cnt_fall, cnt_rise;
  logic                     wrapped;
  logic signed [REAL_W-1:0] real_d;
  logic [RPM_W-1:0]         rpm_clamped;

  always_comb begin
    cnt_fall = last_count_q - encoder_count_i;
    cnt_rise = encoder_count_i - last_count_q;
    wrapped  = (encoder_count_i < last_count_q) && (32'(cnt_fall) > WRAP_JUMP);
    if (wrapped) real_d = $signed({1'b0, cnt_rise});
    else real_d = $signed(REAL_W'(encoder_count_i)) - $signed(REAL_W'(last_count_q));
    rpm_clamped = (target_rpm_i > spd_limit_q) ? spd_limit_q : target_rpm_i;
  end

  // One restoring division step by the constant 60000.
  logic [REM_W:0]   div_trial;
  logic             div_ge;
  logic [REM_W-1:0] div_rem;

  always_comb begin
    div_trial = {rem_q, dvd_q[DVD_W-1]};
    div_ge    = div_trial >= (REM_W + 1)'(MS_PER_MIN);
    div_rem   = div_ge ? REM_W'(div_trial - (REM_W + 1)'(MS_PER_MIN)) : div_trial[REM_W-1:0];
  end

  // Wide helper values; each state uses only a few of them.
  logic signed [WIDE_W-1:0] target_w, real_w, err_w, diff_w, dsrc_w;
  logic signed [WIDE_W-1:0] pwm_w, prop_w, hi_w, lo_w, isum_w, integ_w, total_w, clip_w;
  logic signed [ACC_W-1:0]  err_d, dsrc_d;
  logic [PWM_W-1:0]         duty_raw;

  always_comb begin
    target_w = WIDE_W'($signed({1'b0, quo_q}));
    real_w   = WIDE_W'(real_q);
    err_w    = target_w - (real_w <<< FRAC_BITS);
    err_d    = sat_acc(err_w);
    diff_w   = real_w - WIDE_W'(last_pulses_q);
    dsrc_w   = diff_w <<< FRAC_BITS;
    dsrc_d   = sat_acc(dsrc_w);
    pwm_w    = $signed(WIDE_W'(pwm_limit_q)) <<< FRAC_BITS;
    prop_w   = WIDE_W'(prop_q);
    hi_w     = (pwm_w > prop_w) ? (pwm_w - prop_w) : '0;
    lo_w     = (prop_w > 0) ? -prop_w : '0;
    isum_w   = WIDE_W'(isum_q);
    if (isum_w > hi_w) integ_w = hi_w;
    else if (isum_w < lo_w) integ_w = lo_w;
    else integ_w = isum_w;
    total_w  = WIDE_W'(total_q);
    if (total_w > pwm_w) clip_w = pwm_w;
    else if (total_w < 0) clip_w = '0;
    else clip_w = total_w;
    duty_raw = PWM_W'(clip_w >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      last_count_q  <= '0;
      integral_q    <= '0;
      last_pulses_q <= '0;
      cur_q         <= '0;
      real_q        <= '0;
      isum_q        <= '0;
      err_q         <= '0;
      prop_q        <= '0;
      dterm_q       <= '0;
      total_q       <= '0;
      duty_q        <= '0;
      dvd_q         <= '0;
      quo_q         <= '0;
      rem_q         <= '0;
      dcnt_q        <= '0;
      mreq_q        <= '0;
      out_valid_q   <= 1'b0;
      out_duty_q    <= '0;
      out_mp_q      <= '0;
    end else begin
      // A start pulse lasts one cycle; no state issues a new one right after.
      if (mreq_q.start) mreq_q.start <= 1'b0;
      // In ST_OUT the output register is handled by the state itself.
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (restart_i) begin
              last_count_q  <= encoder_count_i;
              integral_q    <= '0;
              last_pulses_q <= '0;
              real_q        <= '0;
              duty_q        <= '0;
              state_q       <= ST_OUT;
            end else begin
              cur_q  <= encoder_count_i;
              real_q <= real_d;
              mreq_q <= '{start: 1'b1, a: MUL_A_W'(ppr_q), b: GAIN_W'(rpm_clamped)};
              state_q <= ST_MUL1;
            end
          end
        end
        ST_MUL1: begin
          if (mrsp.done) begin
            mreq_q  <= '{start: 1'b1, a: MUL_A_W'(mrsp.prod[P1_W-1:0]),
                         b: GAIN_W'(frame_ms_q)};
            state_q <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (mrsp.done) begin
            dvd_q   <= {mrsp.prod[P2_W-1:0], {FRAC_BITS{1'b0}}};
            quo_q   <= '0;
            rem_q   <= '0;
            dcnt_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= div_rem;
          quo_q  <= {quo_q[DVD_W-2:0], div_ge};
          dvd_q  <= dvd_q << 1;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCNT_W'(DVD_W - 1)) state_q <= ST_ERR;
        end
        ST_ERR: begin
          err_q   <= err_d;
          mreq_q  <= '{start: 1'b1, a: MUL_A_W'(err_d), b: gain_p_q};
          state_q <= ST_GP;
        end
        ST_GP: begin
          if (mrsp.done) begin
            prop_q  <= gain_scale(mrsp.prod);
            mreq_q  <= '{start: 1'b1, a: MUL_A_W'(err_q), b: gain_i_q};
            state_q <= ST_GI;
          end
        end
        ST_GI: begin
          if (mrsp.done) begin
            isum_q  <= ISUM_W'(integral_q) + ISUM_W'(gain_scale(mrsp.prod));
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          // Anti-windup: keep P + I inside 0 .. pwm_limit while P lies in that range.
          integral_q <= INT_W'(integ_w);
          mreq_q     <= '{start: 1'b1, a: MUL_A_W'(dsrc_d), b: gain_d_q};
          state_q    <= ST_GD;
        end
        ST_GD: begin
          if (mrsp.done) begin
            dterm_q <= gain_scale(mrsp.prod);
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          total_q <= TOT_W'(prop_q) + TOT_W'(dterm_q) + TOT_W'(integral_q);
          state_q <= ST_CLIP;
        end
        ST_CLIP: begin
          duty_q        <= (duty_raw < dead_band_q) ? '0 : duty_raw;
          last_count_q  <= cur_q;
          last_pulses_q <= real_q;
          state_q       <= ST_OUT;
        end
        ST_OUT: begin
          // Wait until the output register is free, then hand the result over.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_duty_q  <= duty_q;
            out_mp_q    <= real_w[MP_W-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign duty_o            = out_duty_q;
  // A zero duty brakes the bridge; otherwise drive forward.
  assign drive_a_o         = (out_duty_q != '0);
  assign drive_b_o         = 1'b0;
  assign measured_pulses_o = out_mp_q;

endmodule

// ===== rtl/epsc_sermul.sv =====
// ----------------------------------------------------------------------------
// epsc_sermul: bit-serial multiplier
// Signed multiplicand times unsigned 16-bit multiplier, one multiplier bit
// per cycle, with a one-cycle done pulse when the product is ready.
// ----------------------------------------------------------------------------
module epsc_sermul import epsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic                      busy_q;
  logic                      done_q;
  logic [MUL_CNT_W-1:0]      cnt_q;
  logic signed [MUL_P_W-1:0] acc_q;
  logic signed [MUL_P_W-1:0] mcand_q;
  logic [GAIN_W-1:0]         mplier_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q   <= 1'b1;
        cnt_q    <= '0;
        acc_q    <= '0;
        mcand_q  <= MUL_P_W'(req_i.a);
        mplier_q <= req_i.b;
      end else if (busy_q) begin
        if (mplier_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q  <= mcand_q <<< 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q + 1'b1;
        if (cnt_q == MUL_CNT_W'(GAIN_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

// ===== sim/encoder_pid_speed_controller_core_test.sv =====
// ----------------------------------------------------------------------------
// encoder_pid_speed_controller_core_test: self-checking bench of the PID core
// Sends control ticks through the request channel under several register
// settings and compares every result with an in-bench speed controller model.
// ----------------------------------------------------------------------------
module encoder_pid_speed_controller_core_test;
  import epsc_pkg::*;

  localparam int unsigned COUNT_BITS = 14;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned ITEMS_PER_PHASE = 150;

  typedef struct {
    logic [PWM_W-1:0] duty;
    logic             drive_a;
    logic             drive_b;
    logic [MP_W-1:0]  pulses;
  } tick_result_t;

  // The scoreboard keeps its own copy of the registers and the loop state and
  // predicts one result per accepted tick.
  class speed_scoreboard;
    logic [GAIN_W-1:0]  kp, ki, kd;
    logic [PWM_W-1:0]   pwm_max, band;
    logic [RPM_W-1:0]   rpm_max;
    logic [PPR_W-1:0]   ppr;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_BITS-1:0] prev_count;
    longint integ;
    longint prev_pulses;
    tick_result_t pending[$];
    int errors;

    function new();
      kp = RST_GAIN_P; ki = RST_GAIN_I; kd = RST_GAIN_D;
      pwm_max = RST_PWM_LIMIT; rpm_max = RST_SPD_LIMIT; band = RST_DEAD_BAND;
      ppr = RST_PPR; frame = RST_FRAME_MS;
      prev_count = '0; integ = 0; prev_pulses = 0; errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_GAIN_P:    kp = v;
        REG_GAIN_I:    ki = v;
        REG_GAIN_D:    kd = v;
        REG_PWM_LIMIT: pwm_max = v;
        REG_SPD_LIMIT: rpm_max = v[RPM_W-1:0];
        REG_DEAD_BAND: band = v;
        REG_PPR:       ppr = v;
        REG_FRAME_MS:  frame = v[FRAME_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip40(longint x);
      if (x > 64'sh7F_FFFF_FFFF) return 64'sh7F_FFFF_FFFF;
      if (x < -64'sh80_0000_0000) return -64'sh80_0000_0000;
      return x;
    endfunction

    // Q8.8 gain times a Q.8 value, floored back to Q.8.
    function longint scaled_gain(logic [GAIN_W-1:0] g, longint v);
      longint p;
      p = longint'({48'd0, g}) * v;
      return clip40(p >>> 8);
    endfunction

    function void note_request(logic [COUNT_BITS-1:0] cnt, logic [RPM_W-1:0] rpm,
                               logic rst);
      tick_result_t r;
      longint rpm_eff, target_q, pulses, err, prop, dterm, hi, lo, total, duty, pwm_q;
      if (rst) begin
        prev_count = cnt; integ = 0; prev_pulses = 0;
        r.duty = '0; r.drive_a = 1'b0; r.drive_b = 1'b0; r.pulses = '0;
        pending.push_back(r);
        return;
      end
      pwm_q = longint'(pwm_max) << FRAC_BITS;
      rpm_eff = (rpm > rpm_max) ? longint'(rpm_max) : longint'(rpm);
      target_q = (rpm_eff * longint'(ppr) * longint'(frame) * (64'sd1 << FRAC_BITS))
                 / MS_PER_MIN;
      // A large fall of the counter is a wrap, a small one a real reversal.
      if (cnt < prev_count && prev_count - cnt > WRAP_JUMP)
        pulses = (64'sd1 << COUNT_BITS) - longint'(prev_count) + longint'(cnt);
      else
        pulses = longint'(cnt) - longint'(prev_count);
      err = clip40(target_q - (pulses <<< FRAC_BITS));
      prop = scaled_gain(kp, err);
      integ += scaled_gain(ki, err);
      // Anti-windup keeps P plus I inside 0..pwm_limit while P lies in that range.
      hi = (pwm_q > prop) ? pwm_q - prop : 0;
      lo = (prop > 0) ? -prop : 0;
      if (integ > hi) integ = hi;
      else if (integ < lo) integ = lo;
      dterm = scaled_gain(kd, clip40((pulses - prev_pulses) <<< FRAC_BITS));
      total = prop + dterm + integ;
      prev_count = cnt;
      prev_pulses = pulses;
      if (total > pwm_q) total = pwm_q;
      else if (total < 0) total = 0;
      duty = total >>> FRAC_BITS;
      if (duty < longint'(band)) duty = 0;
      r.duty = duty[PWM_W-1:0];
      r.drive_a = (duty != 0);
      r.drive_b = 1'b0;
      r.pulses = pulses[MP_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: duty %0d pulses %0d", $time,
                 got.duty, $signed(got.pulses));
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.duty !== want.duty) begin
        $display("%0t: duty expected %0d actual %0d", $time, want.duty, got.duty);
        errors++;
      end
      if (got.drive_a !== want.drive_a) begin
        $display("%0t: drive_a expected %0b actual %0b", $time, want.drive_a,
                 got.drive_a);
        errors++;
      end
      if (got.drive_b !== want.drive_b) begin
        $display("%0t: drive_b expected %0b actual %0b", $time, want.drive_b,
                 got.drive_b);
        errors++;
      end
      if (got.pulses !== want.pulses) begin
        $display("%0t: measured_pulses expected %0d actual %0d", $time,
                 $signed(want.pulses), $signed(got.pulses));
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [COUNT_BITS-1:0] encoder_count_i;
  logic [RPM_W-1:0]      target_rpm_i;
  logic                  restart_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PWM_W-1:0]      duty_o;
  logic                  drive_a_o;
  logic                  drive_b_o;
  logic signed [MP_W-1:0] measured_pulses_o;

  speed_scoreboard sb = new();
  // While set, neither side inserts idle cycles.
  logic no_idle = 1'b0;
  logic [COUNT_BITS-1:0] enc_pos = '0;

  encoder_pid_speed_controller_core #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .encoder_count_i  (encoder_count_i),
    .target_rpm_i     (target_rpm_i),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .duty_o           (duty_o),
    .drive_a_o        (drive_a_o),
    .drive_b_o        (drive_b_o),
    .measured_pulses_o(measured_pulses_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls at random unless no_idle is set, and checks every
  // result that is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t got;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.duty = duty_o;
        got.drive_a = drive_a_o;
        got.drive_b = drive_b_o;
        got.pulses = measured_pulses_o;
        sb.check_result(got);
      end
      out_ready_i <= no_idle || ($urandom_range(99) >= 8);
    end
  end

  // Register write: raised on one edge, taken and dropped on the next.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic write_all(logic [CFG_W-1:0] p, logic [CFG_W-1:0] i,
                           logic [CFG_W-1:0] d, logic [CFG_W-1:0] pwm,
                           logic [CFG_W-1:0] spd, logic [CFG_W-1:0] band,
                           logic [CFG_W-1:0] ppr, logic [CFG_W-1:0] frame);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_PWM_LIMIT, pwm);
    write_reg(REG_SPD_LIMIT, spd);
    write_reg(REG_DEAD_BAND, band);
    write_reg(REG_PPR, ppr);
    write_reg(REG_FRAME_MS, frame);
  endtask

  // Holds one request until it is taken; valid stays high for the caller
  // to either send the next request or drop it.
  task automatic send_tick(logic [COUNT_BITS-1:0] cnt, logic [RPM_W-1:0] rpm,
                           logic rst);
    in_valid_i      <= 1'b1;
    encoder_count_i <= cnt;
    target_rpm_i    <= rpm;
    restart_i       <= rst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(cnt, rpm, rst);
  endtask

  task automatic maybe_pause();
    int n;
    if (!no_idle && $urandom_range(99) < 8) begin
      n = $urandom_range(1, 20);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Waits for every expected result, then lets the core run dry.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly a turning motor with small forward steps, some reversal, some
  // arbitrary counter jumps and the odd restart.
  task automatic random_ticks(int n);
    int sel;
    logic [RPM_W-1:0] rpm;
    logic rst;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      rst = 1'b0;
      if (sel < 3) begin
        rst = 1'b1;
        enc_pos = COUNT_BITS'($urandom_range(16383));
      end else if (sel < 12) begin
        enc_pos = COUNT_BITS'($urandom_range(16383));
      end else if (sel < 20) begin
        enc_pos = enc_pos - COUNT_BITS'($urandom_range(300));
      end else begin
        enc_pos = enc_pos + COUNT_BITS'($urandom_range(400));
      end
      rpm = ($urandom_range(1) != 0) ? RPM_W'($urandom_range(8191))
                                     : RPM_W'($urandom_range(400));
      send_tick(enc_pos, rpm, rst);
      maybe_pause();
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_GAIN_P;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    encoder_count_i <= '0;
    target_rpm_i    <= '0;
    restart_i       <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks on the reset settings: target clamp, counter wrap,
    // small and large falls, full-range rise and restarts.
    send_tick(14'd0, 13'd0, 1'b1);
    send_tick(14'd100, 13'd8191, 1'b0);
    send_tick(14'd16383, 13'd0, 1'b0);
    send_tick(14'd5, 13'd300, 1'b0);
    send_tick(14'd0, 13'd301, 1'b0);
    send_tick(14'd16383, 13'd299, 1'b0);
    send_tick(14'd0, 13'd150, 1'b0);
    send_tick(14'd8000, 13'd1, 1'b0);
    send_tick(14'd0, 13'd300, 1'b0);
    send_tick(14'd16383, 13'd8191, 1'b1);
    send_tick(14'd16000, 13'd300, 1'b0);
    send_tick(14'd1, 13'd299, 1'b0);
    send_tick(14'd15, 13'd300, 1'b0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all(16'd512, 16'd64, 16'd128, 16'd1000, 16'd300, 16'd50,
                     16'd1320, 16'd20);
        1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF);
        2: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        3: write_all(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
                     CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
                     CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
                     CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)));
        4: write_all(CFG_W'($urandom_range(2048)), CFG_W'($urandom_range(256)),
                     CFG_W'($urandom_range(512)), CFG_W'($urandom_range(4000)),
                     CFG_W'($urandom_range(8191)), CFG_W'($urandom_range(200)),
                     16'd1, 16'd1);
        default: write_all(CFG_W'($urandom_range(1024)), CFG_W'($urandom_range(128)),
                           CFG_W'($urandom_range(256)), 16'd65535, 16'd8191,
                           CFG_W'($urandom_range(100)),
                           CFG_W'($urandom_range(1, 4000)),
                           CFG_W'($urandom_range(1, 1000)));
      endcase
      no_idle = (phase == 4);
      send_tick(enc_pos, 13'd0, 1'b1);
      random_ticks(ITEMS_PER_PHASE);
      drain();
      no_idle = 1'b0;
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
